// ===== src/glq_pkg.sv =====
// Shared constants, types and the gain coefficient table for the LQR torque core.
package glq_pkg;

    localparam int NERR = 6;
    localparam int NROW = 12;
    localparam int NCOEF = 36;
    localparam int EW = 33;
    localparam int HW = 17;
    localparam int XW = 2 * HW;
    localparam int PRW = 2 * XW;
    localparam int NSTG = 16;
    localparam int ST_GAIN = 2;
    localparam int ST_TERM = 7;
    localparam int ST_SUM = 13;
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Gain polynomial coefficients in millionths, rows of (c2, c1, c0).
    // Rows 0 to 5 feed the wheel torque, rows 6 to 11 the hip torque.
    localparam longint COEF_MICRO [NCOEF] = '{
        60071162, -57303242, -8802552,
        -219882, -1390464, -951558,
        32409644, -23635877, -9253521,
        12436266, -10318639, -7529540,
        135956804, -124044032, 36093582,
        13977819, -12325081, 3766791,
        32632159, -39012888, 14483707,
        7204778, -5973109, 1551763,
        78723013, -73096567, 21701734,
        63798027, -55564993, 15318437,
        -195813486, 140134182, 60699132,
        -18357761, 13165559, 2581731
    };

    typedef logic [EW-1:0] t_emag;
    typedef t_emag [NERR-1:0] t_emag_vec;
    typedef logic [NERR-1:0] t_sgn_vec;

    // Coefficient rounded half away from zero to frac fraction bits.
    function automatic longint coef_q(input int idx, input int frac);
        longint c;
        longint m;
        c = COEF_MICRO[idx];
        m = (c < 0) ? -c : c;
        m = ((m <<< frac) + 64'sd500000) / 64'sd1000000;
        return (c < 0) ? -m : m;
    endfunction

endpackage

// ===== src/glq_err.sv =====
// Front stages: state errors as sign and magnitude, and rounded leg length square.
module glq_err (
    input  logic                i_clk,
    input  logic [1:0]          i_en,
    input  logic [15:0]         i_len,
    input  logic [31:0]         i_angle,
    input  logic [31:0]         i_angle_rate,
    input  logic [31:0]         i_tgt_dist,
    input  logic [31:0]         i_meas_dist,
    input  logic [31:0]         i_tgt_speed,
    input  logic [31:0]         i_meas_speed,
    input  logic [31:0]         i_pitch,
    input  logic [31:0]         i_pitch_rate,
    output logic [15:0]         o_len,
    output logic [15:0]         o_lsq,
    output glq_pkg::t_emag_vec  o_emag,
    output glq_pkg::t_sgn_vec   o_eneg
);
    import glq_pkg::*;

    logic [15:0]        r_len0;
    logic [31:0]        r_sq;
    logic signed [EW-1:0] r_err [NERR];
    logic [15:0]        r_len1;
    logic [15:0]        r_lsq;
    t_emag_vec          r_emag;
    t_sgn_vec           r_eneg;
    logic [31:0]        w_sqr;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_len0 <= i_len;
            r_sq   <= 32'(i_len) * 32'(i_len);
            r_err[0] <= -$signed({i_angle[31], i_angle});
            r_err[1] <= -$signed({i_angle_rate[31], i_angle_rate});
            r_err[2] <= $signed({i_tgt_dist[31], i_tgt_dist})
                      - $signed({i_meas_dist[31], i_meas_dist});
            r_err[3] <= $signed({i_tgt_speed[31], i_tgt_speed})
                      - $signed({i_meas_speed[31], i_meas_speed});
            r_err[4] <= -$signed({i_pitch[31], i_pitch});
            r_err[5] <= -$signed({i_pitch_rate[31], i_pitch_rate});
        end
    end

    assign w_sqr = r_sq + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_len1 <= r_len0;
            r_lsq  <= w_sqr[31:16];
            for (int k = 0; k < NERR; k++) begin
                r_eneg[k] <= r_err[k][EW-1];
                r_emag[k] <= r_err[k][EW-1] ? EW'(-r_err[k]) : EW'(r_err[k]);
            end
        end
    end

    assign o_len  = r_len1;
    assign o_lsq  = r_lsq;
    assign o_emag = r_emag;
    assign o_eneg = r_eneg;

endmodule

// ===== src/glq_gain.sv =====
// Gain scheduling: twelve quadratic gains in leg length over five stages.
module glq_gain #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic [4:0]                               i_en,
    input  logic [15:0]                              i_len,
    input  logic [15:0]                              i_lsq,
    input  glq_pkg::t_emag_vec                       i_emag,
    input  glq_pkg::t_sgn_vec                        i_eneg,
    output logic [glq_pkg::NROW-1:0][FRAC_BITS+9:0]  o_gain,
    output glq_pkg::t_emag_vec                       o_emag,
    output glq_pkg::t_sgn_vec                        o_eneg
);
    import glq_pkg::*;

    localparam int CW = FRAC_BITS + 9;
    localparam int PW = CW + 17;
    localparam int MW = PW - 14;
    localparam int GW = FRAC_BITS + 10;
    localparam int RND = 1 << 15;

    // Errors ride along so that they meet their gains at the product stages.
    t_emag_vec r_emd [5];
    t_sgn_vec  r_end [5];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_emd[0] <= i_emag;
            r_end[0] <= i_eneg;
        end
        for (int k = 1; k < 5; k++) begin
            if (i_en[k]) begin
                r_emd[k] <= r_emd[k-1];
                r_end[k] <= r_end[k-1];
            end
        end
    end

    assign o_emag = r_emd[4];
    assign o_eneg = r_end[4];

    for (genvar r = 0; r < NROW; r++) begin : g_row
        localparam longint L2 = coef_q(3 * r, FRAC_BITS);
        localparam longint L1 = coef_q(3 * r + 1, FRAC_BITS);
        localparam longint L0 = coef_q(3 * r + 2, FRAC_BITS);
        localparam logic signed [CW-1:0] K2 = CW'(L2);
        localparam logic signed [CW-1:0] K1 = CW'(L1);
        localparam logic signed [CW-1:0] K0 = CW'(L0);

        logic signed [PW-1:0] r_p2;
        logic signed [PW-1:0] r_p1;
        logic signed [PW:0]   r_s;
        logic [PW:0]          r_m;
        logic                 r_neg4;
        logic [MW-1:0]        r_mr;
        logic                 r_neg5;
        logic [GW-1:0]        r_g;
        logic [PW+1:0]        w_rnd;
        logic signed [MW:0]   w_sm;
        logic signed [MW+1:0] w_g;

        assign w_rnd = (PW+2)'(r_m) + (PW+2)'(RND);
        assign w_sm  = r_neg5 ? -$signed({1'b0, r_mr}) : $signed({1'b0, r_mr});
        assign w_g   = (MW+2)'(w_sm) + (MW+2)'(K0);

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_p2 <= K2 * $signed({1'b0, i_lsq});
                r_p1 <= K1 * $signed({1'b0, i_len});
            end
            if (i_en[1]) begin
                r_s <= (PW+1)'(r_p2) + (PW+1)'(r_p1);
            end
            if (i_en[2]) begin
                r_neg4 <= r_s[PW];
                r_m    <= r_s[PW] ? (PW+1)'(-r_s) : (PW+1)'(r_s);
            end
            if (i_en[3]) begin
                r_neg5 <= r_neg4;
                r_mr   <= w_rnd[PW+1:16];
            end
            if (i_en[4]) begin
                r_g <= w_g[GW-1:0];
            end
        end

        assign o_gain[r] = r_g;
    end

endmodule

// ===== src/glq_term.sv =====
// One gain times error product, split into four partials, rounded to the data format.
module glq_term #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic [5:0]                        i_en,
    input  logic [FRAC_BITS+9:0]              i_gain,
    input  glq_pkg::t_emag                    i_emag,
    input  logic                              i_eneg,
    output logic [glq_pkg::PRW-FRAC_BITS-1:0] o_term
);
    import glq_pkg::*;

    localparam int GW = FRAC_BITS + 10;
    localparam int TW = PRW - FRAC_BITS;

    logic [GW-1:0]     r_gm;
    t_emag             r_em;
    logic              r_sgn [5];
    logic [XW-1:0]     r_hh;
    logic [XW-1:0]     r_hl;
    logic [XW-1:0]     r_lh;
    logic [XW-1:0]     r_ll;
    logic [XW-1:0]     r_hh2;
    logic [XW-1:0]     r_ll2;
    logic [XW:0]       r_mid;
    logic [PRW-1:0]    r_prod;
    logic [TW-1:0]     r_rm;
    logic [TW-1:0]     r_t;
    logic [XW-1:0]     w_a;
    logic [XW-1:0]     w_b;
    logic [PRW-1:0]    w_r;

    assign w_a = XW'(r_gm);
    assign w_b = XW'(r_em);
    assign w_r = r_prod + (PRW'(1) << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_gm     <= i_gain[GW-1] ? GW'(-$signed(i_gain)) : i_gain;
            r_em     <= i_emag;
            r_sgn[0] <= i_gain[GW-1] ^ i_eneg;
        end
        for (int k = 1; k < 5; k++) begin
            if (i_en[k]) begin
                r_sgn[k] <= r_sgn[k-1];
            end
        end
        if (i_en[1]) begin
            r_hh <= XW'(w_a[XW-1:HW]) * XW'(w_b[XW-1:HW]);
            r_hl <= XW'(w_a[XW-1:HW]) * XW'(w_b[HW-1:0]);
            r_lh <= XW'(w_a[HW-1:0]) * XW'(w_b[XW-1:HW]);
            r_ll <= XW'(w_a[HW-1:0]) * XW'(w_b[HW-1:0]);
        end
        if (i_en[2]) begin
            r_mid <= (XW+1)'(r_hl) + (XW+1)'(r_lh);
            r_hh2 <= r_hh;
            r_ll2 <= r_ll;
        end
        if (i_en[3]) begin
            r_prod <= (PRW'(r_hh2) << XW) + (PRW'(r_mid) << HW) + PRW'(r_ll2);
        end
        if (i_en[4]) begin
            r_rm <= w_r[PRW-1:FRAC_BITS];
        end
        if (i_en[5]) begin
            r_t <= r_sgn[4] ? (TW'(0) - r_rm) : r_rm;
        end
    end

    assign o_term = r_t;

endmodule

// ===== src/glq_sum.sv =====
// Adds six terms per torque in two stages and saturates to 32 bits.
module glq_sum #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                                  i_clk,
    input  logic [2:0]                                            i_en,
    input  logic [glq_pkg::NROW-1:0][glq_pkg::PRW-FRAC_BITS-1:0]  i_term,
    output logic [1:0][31:0]                                      o_trq
);
    import glq_pkg::*;

    localparam int TW = PRW - FRAC_BITS;
    localparam int SW = TW + 3;

    for (genvar s = 0; s < 2; s++) begin : g_side
        logic signed [TW:0]   r_pr [3];
        logic signed [SW-1:0] r_tot;
        logic [31:0]          r_sat;
        logic [SW-32:0]       w_hi;
        logic                 w_fit;

        assign w_hi  = r_tot[SW-1:31];
        assign w_fit = (&w_hi) || (~|w_hi);

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[j] <= (TW+1)'($signed(i_term[6*s+2*j]))
                             + (TW+1)'($signed(i_term[6*s+2*j+1]));
                end
            end
            if (i_en[1]) begin
                r_tot <= SW'(r_pr[0]) + SW'(r_pr[1]) + SW'(r_pr[2]);
            end
            if (i_en[2]) begin
                if (w_fit) begin
                    r_sat <= r_tot[31:0];
                end else begin
                    r_sat <= r_tot[SW-1] ? SAT_MIN : SAT_MAX;
                end
            end
        end

        assign o_trq[s] = r_sat;
    end

endmodule

// ===== src/gain_scheduled_lqr_torque_core.sv =====
// Top level of the gain-scheduled LQR torque core: handshake, valid pipeline and datapath.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         272    leg length and eight state words, one word per item
//  m_axis    out        64     wheel torque and hip torque, one word per item
//
// One word enters per cycle while the pipeline is not stalled; each passes through the 16
// register stages of the datapath (errors, gain polynomial, split product,
// rounding, adder tree, saturation).
// Every stage stalls only when it is full and the stage after it is full and
// stalled, so bubbles close up and input is still taken while a result waits.
// Reset clears the valid bits only; the datapath holds no state between words.
module gain_scheduled_lqr_torque_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // leg_length[15:0], leg_angle[47:16], leg_angle_rate[79:48],
    // target_distance[111:80], measured_distance[143:112], target_speed[175:144],
    // measured_speed[207:176], body_pitch[239:208], body_pitch_rate[271:240]
    input  logic [271:0]  i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // wheel_torque[31:0], hip_torque[63:32]
    output logic [63:0]   o_m_axis_tdata
);
    import glq_pkg::*;

    localparam int GW = FRAC_BITS + 10;
    localparam int TW = PRW - FRAC_BITS;

    logic [NSTG-1:0]            r_vld;
    logic [NSTG-1:0]            n_vld;
    logic [NSTG-1:0]            w_en;

    logic [15:0]                w_len;
    logic [15:0]                w_lsq;
    t_emag_vec                  w_emag;
    t_sgn_vec                   w_eneg;
    logic [NROW-1:0][GW-1:0]    w_gain;
    t_emag_vec                  w_emag_g;
    t_sgn_vec                   w_eneg_g;
    logic [NROW-1:0][TW-1:0]    w_term;
    logic [1:0][31:0]           w_trq;

    // A stage may load when it is empty or when the next stage loads too.
    assign w_en[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = w_trq;

    glq_err u_err (
        .i_clk        (i_clk),
        .i_en         (w_en[ST_GAIN-1:0]),
        .i_len        (i_s_axis_tdata[15:0]),
        .i_angle      (i_s_axis_tdata[47:16]),
        .i_angle_rate (i_s_axis_tdata[79:48]),
        .i_tgt_dist   (i_s_axis_tdata[111:80]),
        .i_meas_dist  (i_s_axis_tdata[143:112]),
        .i_tgt_speed  (i_s_axis_tdata[175:144]),
        .i_meas_speed (i_s_axis_tdata[207:176]),
        .i_pitch      (i_s_axis_tdata[239:208]),
        .i_pitch_rate (i_s_axis_tdata[271:240]),
        .o_len        (w_len),
        .o_lsq        (w_lsq),
        .o_emag       (w_emag),
        .o_eneg       (w_eneg)
    );

    glq_gain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_gain (
        .i_clk  (i_clk),
        .i_en   (w_en[ST_TERM-1:ST_GAIN]),
        .i_len  (w_len),
        .i_lsq  (w_lsq),
        .i_emag (w_emag),
        .i_eneg (w_eneg),
        .o_gain (w_gain),
        .o_emag (w_emag_g),
        .o_eneg (w_eneg_g)
    );

    for (genvar r = 0; r < NROW; r++) begin : g_term
        glq_term #(
            .FRAC_BITS (FRAC_BITS)
        ) u_term (
            .i_clk  (i_clk),
            .i_en   (w_en[ST_SUM-1:ST_TERM]),
            .i_gain (w_gain[r]),
            .i_emag (w_emag_g[r % NERR]),
            .i_eneg (w_eneg_g[r % NERR]),
            .o_term (w_term[r])
        );
    end

    glq_sum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .i_clk  (i_clk),
        .i_en   (w_en[NSTG-1:ST_SUM]),
        .i_term (w_term),
        .o_trq  (w_trq)
    );

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while every stage is full and the output stalls");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_vld & $past(r_vld & ~w_en)) == $past(r_vld & ~w_en)))
        else $error("a stalled stage lost its word");

endmodule
